[rtl/core/ktsp_pkg.sv]
package ktsp_pkg;

  localparam int KeyW     = 32;
  localparam int ReqW     = 2;
  localparam int SlotW    = 12;
  localparam int StatusW  = 3;
  localparam int SlotCntW = 13;

  localparam int DefTableEntries = 4096;
  localparam int DefMaxSlots     = 4096;

  localparam logic [SlotCntW-1:0] SlotLimitReset = 13'd4096;

  // Request codes
  localparam logic [ReqW-1:0] ReqAdd    = 2'd0;
  localparam logic [ReqW-1:0] ReqLookup = 2'd1;
  localparam logic [ReqW-1:0] ReqClear  = 2'd2;

  // Result status codes
  localparam logic [StatusW-1:0] StNew        = 3'd0;
  localparam logic [StatusW-1:0] StFound      = 3'd1;
  localparam logic [StatusW-1:0] StRegionFull = 3'd2;
  localparam logic [StatusW-1:0] StTableFull  = 3'd3;
  localparam logic [StatusW-1:0] StBadKey     = 3'd4;
  localparam logic [StatusW-1:0] StCleared    = 3'd5;

  typedef struct packed {
    logic [ReqW-1:0] req_type;
    logic [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic [SlotW-1:0]   slot;
    logic [StatusW-1:0] status;
  } res_t;

endpackage

[rtl/core/key_to_slot_probing_hash_map_top.sv]
// Steps: a bad key answers straight from idle; an add or lookup reads and compares each probed
//   entry in turn, after the SMod, SMul and SFix remainder states when TABLE_ENTRIES is not a power of two.
// Throughput: one item at a time; busy stays high while the probe loop over the single
//   table read port runs. A clear holds busy high while it sweeps the table, one entry a cycle.
// Reset: asynchronous, active low; the key store is then swept to empty with busy
//   high. Results strobe for one cycle and cannot be stalled.
module key_to_slot_probing_hash_map_top import ktsp_pkg::*; #(
  parameter int TABLE_ENTRIES = DefTableEntries,
  parameter int MAX_SLOTS     = DefMaxSlots
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  req_t                req_i,
  input  logic                cfg_we_i,
  input  logic [SlotCntW-1:0] cfg_wdata_i,
  output logic                res_valid_o,
  output res_t                res_o
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam bit IsPow2 = (TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(TABLE_ENTRIES - 1);

  // Reciprocal of the table size, scaled so that it fits the key width; the
  // quotient it gives is never above the true one and at most one below it
  localparam int RecipShift = KeyW - 1 + IdxW;
  localparam logic [2*KeyW-1:0] RecipFull =
    ((2*KeyW)'(1) << RecipShift) / (2*KeyW)'(TABLE_ENTRIES);
  localparam logic [KeyW-1:0] RecipM = RecipFull[KeyW-1:0];

  // Sequencer state codes
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SMod   = 3'd1;
  localparam logic [2:0] SRead  = 3'd2;
  localparam logic [2:0] SCmp   = 3'd3;
  localparam logic [2:0] SInit  = 3'd4;
  localparam logic [2:0] SClear = 3'd5;
  localparam logic [2:0] SMul   = 3'd6;
  localparam logic [2:0] SFix   = 3'd7;

  logic [2:0]          state_q, state_d;
  logic [IdxW-1:0]     pos_q, pos_d;
  logic [IdxW-1:0]     probe_q, probe_d;
  logic [2*KeyW-1:0]   prod_q, prod_d;
  logic [KeyW-1:0]     key_q, key_d;
  logic [SlotCntW-1:0] slots_used_q, slots_used_d;
  logic [SlotCntW-1:0] slot_limit_q;
  logic                res_valid_q, res_valid_d;
  res_t                res_q, res_d;

  logic [SlotCntW-1:0] lim;
  logic [KeyW-1:0]     mul_a, mul_b;
  logic [2*KeyW-1:0]   mul_p;
  logic [IdxW:0]       rem_est;
  logic [IdxW-1:0]     rem_next;
  logic                wr_key_en, wr_slot_en;
  logic [KeyW-1:0]     wr_key;
  logic [KeyW-1:0]     rd_key;
  logic [SlotW-1:0]    rd_slot;
  logic                accept;

  assign busy   = (state_q != SIdle);
  assign accept = start && !busy;

  // Limit in force: the smaller of the register and the slot capacity
  assign lim = (32'(slot_limit_q) < MAX_SLOTS) ? slot_limit_q : SlotCntW'(MAX_SLOTS);

  // Shared multiplier: key by reciprocal first, then quotient by table size
  assign mul_p = (2*KeyW)'(mul_a) * (2*KeyW)'(mul_b);

  // Remainder estimate lies below twice the table size: subtract it once at most
  assign rem_est  = prod_q[IdxW:0];
  assign rem_next = (rem_est >= (IdxW+1)'(TABLE_ENTRIES)) ?
                    IdxW'(rem_est - (IdxW+1)'(TABLE_ENTRIES)) : IdxW'(rem_est);

  ktsp_table #(
    .TABLE_ENTRIES(TABLE_ENTRIES)
  ) u_table (
    .clk_i       (clk_i),
    .wr_key_en_i (wr_key_en),
    .wr_slot_en_i(wr_slot_en),
    .wr_addr_i   (pos_q),
    .wr_key_i    (wr_key),
    .wr_slot_i   (slots_used_q[SlotW-1:0]),
    .rd_addr_i   (pos_q),
    .rd_key_o    (rd_key),
    .rd_slot_o   (rd_slot)
  );

  always_comb begin
    state_d      = state_q;
    pos_d        = pos_q;
    probe_d      = probe_q;
    prod_d       = prod_q;
    key_d        = key_q;
    slots_used_d = slots_used_q;
    res_valid_d  = 1'b0;
    res_d        = res_q;
    wr_key_en    = 1'b0;
    wr_slot_en   = 1'b0;
    wr_key       = key_q;
    mul_a        = key_q;
    mul_b        = RecipM;

    unique case (state_q)
      SIdle: begin
        if (accept) begin
          unique case (req_i.req_type) inside
            ReqClear: begin
              // Empty the table with a sweep, slot count restarts at zero
              pos_d        = '0;
              slots_used_d = '0;
              state_d      = SClear;
            end
            ReqAdd, ReqLookup: begin
              if (req_i.key == '0) begin
                res_valid_d = 1'b1;
                res_d       = '{slot: '0, status: StBadKey};
              end else begin
                key_d   = req_i.key;
                probe_d = '0;
                if (IsPow2) begin
                  pos_d   = req_i.key[IdxW-1:0];
                  state_d = SRead;
                end else begin
                  state_d = SMod;
                end
              end
            end
            default: begin
              res_valid_d = 1'b1;
              res_d       = '{slot: '0, status: StBadKey};
            end
          endcase
        end
      end
      SMod: begin
        // Scale the key by the reciprocal of the table size
        prod_d  = mul_p;
        state_d = SMul;
      end
      SMul: begin
        // Take the quotient estimate back off the key
        mul_a   = KeyW'(prod_q >> RecipShift);
        mul_b   = KeyW'(TABLE_ENTRIES);
        prod_d  = {{KeyW{1'b0}}, key_q - mul_p[KeyW-1:0]};
        state_d = SFix;
      end
      SFix: begin
        // Fold the estimate into range to get the home entry
        pos_d   = rem_next;
        state_d = SRead;
      end
      SRead: begin
        // Wait for the registered table read at pos_q
        state_d = SCmp;
      end
      SCmp: begin
        if (rd_key == key_q) begin
          res_valid_d = 1'b1;
          res_d       = '{slot: rd_slot, status: StFound};
          state_d     = SIdle;
        end else if (rd_key == '0) begin
          res_valid_d = 1'b1;
          state_d     = SIdle;
          if (slots_used_q < lim) begin
            // Claim the empty entry and hand out the next slot
            wr_key_en    = 1'b1;
            wr_slot_en   = 1'b1;
            slots_used_d = slots_used_q + SlotCntW'(1);
            res_d        = '{slot: slots_used_q[SlotW-1:0], status: StNew};
          end else begin
            res_d = '{slot: '0, status: StRegionFull};
          end
        end else if (probe_q == LastIdx) begin
          res_valid_d = 1'b1;
          res_d       = '{slot: '0, status: StTableFull};
          state_d     = SIdle;
        end else begin
          // Advance to the next entry, wrapping round the table
          probe_d = probe_q + IdxW'(1);
          pos_d   = (pos_q == LastIdx) ? '0 : pos_q + IdxW'(1);
          state_d = SRead;
        end
      end
      SInit, SClear: begin
        wr_key_en = 1'b1;
        wr_key    = '0;
        if (pos_q == LastIdx) begin
          pos_d   = '0;
          state_d = SIdle;
          if (state_q == SClear) begin
            res_valid_d = 1'b1;
            res_d       = '{slot: '0, status: StCleared};
          end
        end else begin
          pos_d = pos_q + IdxW'(1);
        end
      end
      default: begin
        state_d = SIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SInit;
      pos_q        <= '0;
      slots_used_q <= '0;
      slot_limit_q <= SlotLimitReset;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      pos_q        <= pos_d;
      slots_used_q <= slots_used_d;
      res_valid_q  <= res_valid_d;
      if (cfg_we_i) begin
        slot_limit_q <= cfg_wdata_i;
      end
    end
  end

  // Payload and loop counters: no reset needed
  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    probe_q <= probe_d;
    prod_q  <= prod_d;
    res_q   <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[rtl/core/ktsp_table.sv]
module ktsp_table import ktsp_pkg::*; #(
  parameter int TABLE_ENTRIES = DefTableEntries,
  localparam int IdxW = $clog2(TABLE_ENTRIES)
) (
  input  logic            clk_i,
  input  logic            wr_key_en_i,
  input  logic            wr_slot_en_i,
  input  logic [IdxW-1:0] wr_addr_i,
  input  logic [KeyW-1:0] wr_key_i,
  input  logic [SlotW-1:0] wr_slot_i,
  input  logic [IdxW-1:0] rd_addr_i,
  output logic [KeyW-1:0] rd_key_o,
  output logic [SlotW-1:0] rd_slot_o
);

  logic [KeyW-1:0]  key_mem  [TABLE_ENTRIES];
  logic [SlotW-1:0] slot_mem [TABLE_ENTRIES];
  logic [KeyW-1:0]  rd_key_q;
  logic [SlotW-1:0] rd_slot_q;

  // Key store: one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (wr_key_en_i) begin
      key_mem[wr_addr_i] <= wr_key_i;
    end
    rd_key_q <= key_mem[rd_addr_i];
  end

  // Slot store: written only when an entry is claimed
  always_ff @(posedge clk_i) begin
    if (wr_slot_en_i) begin
      slot_mem[wr_addr_i] <= wr_slot_i;
    end
    rd_slot_q <= slot_mem[rd_addr_i];
  end

  assign rd_key_o  = rd_key_q;
  assign rd_slot_o = rd_slot_q;

endmodule

[bench/key_to_slot_probing_hash_map_top_tb.sv]
module key_to_slot_probing_hash_map_top_tb;
  import ktsp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TblEntries = DefTableEntries;
  localparam int MaxSlots   = DefMaxSlots;
  // The package leaves code 3 unnamed; it must answer as a bad key.
  localparam logic [ReqW-1:0] ReqUnused = 2'd3;
  // Far above the slowest correct run: reset sweep, a few dozen clears of the
  // whole table and long probe chains under the widest gaps.
  localparam int unsigned CycleLimit = 2_000_000;
  localparam int DirRows = 25;

  typedef enum logic {RowItem, RowCfg} row_kind_e;

  // One line of the directed table: either a register write or an item,
  // with the result typed in where it is plain to see.
  typedef struct packed {
    row_kind_e           kind;
    logic [SlotCntW-1:0] cap;
    req_t                req;
    logic                typed;
    res_t                res;
  } dir_row_t;

  logic                clk_i;
  logic                rst_ni;
  logic                start;
  logic                busy;
  req_t                req_i;
  logic                cfg_we_i;
  logic [SlotCntW-1:0] cfg_wdata_i;
  logic                res_valid_o;
  res_t                res_o;

  // Own copy of the map: entry keys, entry slots, slot count and limit.
  logic [KeyW-1:0]  map_key  [TblEntries];
  logic [SlotW-1:0] map_slot [TblEntries];
  int unsigned      slots_taken;
  int unsigned      slot_cap;

  res_t            slot_results_due[$];
  logic [KeyW-1:0] live_keys[$];
  res_t            oldest_res;
  int unsigned     mismatches;
  int unsigned     cycle_count;
  int unsigned     burst_left;
  bit              steady;

  dir_row_t dir_rows [DirRows] = '{
    '{RowItem, 13'd0, '{ReqLookup, 32'h0000_0000}, 1'b1, '{12'd0, StBadKey}},
    '{RowItem, 13'd0, '{ReqAdd,    32'h0000_0000}, 1'b1, '{12'd0, StBadKey}},
    '{RowItem, 13'd0, '{ReqUnused, 32'hFFFF_FFFF}, 1'b1, '{12'd0, StBadKey}},
    '{RowItem, 13'd0, '{ReqAdd,    32'hFFFF_FFFF}, 1'b1, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqLookup, 32'hFFFF_FFFF}, 1'b1, '{12'd0, StFound}},
    '{RowItem, 13'd0, '{ReqAdd,    32'hFFFF_FFFF}, 1'b1, '{12'd0, StFound}},
    // same home entry as the last one: wrap round to entry 0
    '{RowItem, 13'd0, '{ReqAdd,    32'h0000_0FFF}, 1'b0, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqLookup, 32'h0000_1FFF}, 1'b0, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqAdd,    32'h0000_0001}, 1'b0, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqLookup, 32'h8000_0000}, 1'b0, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqLookup, 32'h0000_1FFF}, 1'b0, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqClear,  32'hDEAD_BEEF}, 1'b1, '{12'd0, StCleared}},
    '{RowItem, 13'd0, '{ReqLookup, 32'hFFFF_FFFF}, 1'b1, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqClear,  32'h0000_0000}, 1'b1, '{12'd0, StCleared}},
    '{RowCfg,  13'd0, '{ReqAdd,    32'h0000_0000}, 1'b0, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqAdd,    32'h0000_0007}, 1'b1, '{12'd0, StRegionFull}},
    '{RowItem, 13'd0, '{ReqLookup, 32'h0000_0FFF}, 1'b1, '{12'd0, StRegionFull}},
    '{RowCfg,  13'd1, '{ReqAdd,    32'h0000_0000}, 1'b0, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqLookup, 32'h1234_5678}, 1'b1, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqAdd,    32'h1234_5678}, 1'b1, '{12'd0, StFound}},
    '{RowItem, 13'd0, '{ReqAdd,    32'h55AA_55AA}, 1'b1, '{12'd0, StRegionFull}},
    '{RowItem, 13'd0, '{ReqUnused, 32'h0000_0000}, 1'b1, '{12'd0, StBadKey}},
    '{RowCfg,  13'd4096, '{ReqAdd, 32'h0000_0000}, 1'b0, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqAdd,    32'h55AA_55AA}, 1'b0, '{12'd0, StNew}},
    '{RowItem, 13'd0, '{ReqClear,  32'hFFFF_FFFF}, 1'b1, '{12'd0, StCleared}}
  };

  key_to_slot_probing_hash_map_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Predict one item and advance the copy of the map.
  function automatic res_t map_request(req_t r);
    res_t        o;
    int unsigned pos;
    int unsigned cap;
    bit          done;
    o = '0;
    if (r.req_type == ReqClear) begin
      for (int i = 0; i < TblEntries; i++) map_key[i] = '0;
      slots_taken = 0;
      o.status = StCleared;
    end else if ((r.req_type != ReqAdd && r.req_type != ReqLookup) || r.key == '0) begin
      o.status = StBadKey;
    end else begin
      pos = r.key % TblEntries;
      cap = (slot_cap < MaxSlots) ? slot_cap : MaxSlots;
      done = 1'b0;
      // a probe that runs round the whole table without a hit stays table full
      o.status = StTableFull;
      for (int n = 0; n < TblEntries && !done; n++) begin
        if (map_key[pos] == r.key) begin
          o.slot = map_slot[pos];
          o.status = StFound;
          done = 1'b1;
        end else if (map_key[pos] == '0) begin
          if (slots_taken < cap) begin
            map_key[pos] = r.key;
            map_slot[pos] = SlotW'(slots_taken);
            o.slot = SlotW'(slots_taken);
            o.status = StNew;
            slots_taken++;
          end else begin
            o.status = StRegionFull;
          end
          done = 1'b1;
        end else begin
          pos = (pos + 1) % TblEntries;
        end
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(string what, int unsigned got, int unsigned want);
    mismatches++;
    if (mismatches <= 40)
      $display("mismatch %0s: got %0d, want %0d at %0t", what, got, want, $time);
  endtask

  // Drop start for a gap whose length is set by n; put noise on the idle request lines.
  task automatic pause(int unsigned n);
    @(negedge clk_i);
    start <= 1'b0;
    req_i <= {2'($urandom), 32'($urandom)};
    repeat (n) @(negedge clk_i);
  endtask

  // Offer one item, hold it until taken, then log its expected result.
  task automatic issue(req_t r, bit typed, res_t typed_res);
    res_t pred;
    @(negedge clk_i);
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy);
    pred = map_request(r);
    slot_results_due.push_back(typed ? typed_res : pred);
    if (pred.status == StNew) live_keys.push_back(r.key);
    if (r.req_type == ReqClear) live_keys.delete();
    if (burst_left > 1) begin
      burst_left--;
    end else begin
      if (!steady)
        pause(($urandom_range(0, 3) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 4));
      burst_left = $urandom_range(1, 12);
    end
  endtask

  // Write the slot limit once every result is in and the block is idle.
  task automatic set_limit(int unsigned cap);
    pause(0);
    while (slot_results_due.size() != 0) @(posedge clk_i);
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= SlotCntW'(cap);
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    slot_cap = cap;
  endtask

  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("[key_to_slot_probing_hash_map_top] ERROR");
    $finish;
  end

  // Results cannot be held off: take each one on the cycle it strobes.
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o === 1'b1) begin
      if (slot_results_due.size() == 0) begin
        report_mismatch("result with none expected", res_o.status, 0);
      end else begin
        oldest_res = slot_results_due.pop_front();
        if (res_o.slot !== oldest_res.slot)
          report_mismatch("slot", res_o.slot, oldest_res.slot);
        if (res_o.status !== oldest_res.status)
          report_mismatch("status", res_o.status, oldest_res.status);
      end
    end
  end

  initial begin
    req_t        r;
    int unsigned cap;
    int unsigned roll;
    logic [11:0] hot_pos [4];
    hot_pos = '{12'h000, 12'hFFF, 12'h011, 12'h800};
    start       = 1'b0;
    req_i       = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rst_ni      = 1'b0;
    mismatches  = 0;
    cycle_count = 0;
    burst_left  = 1;
    steady      = 1'b0;
    slots_taken = 0;
    slot_cap    = SlotLimitReset;
    for (int i = 0; i < TblEntries; i++) begin
      map_key[i]  = '0;
      map_slot[i] = '0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: extremes, every request code, the named corner cases.
    for (int i = 0; i < DirRows; i++) begin
      if (dir_rows[i].kind == RowCfg)
        set_limit(dir_rows[i].cap);
      else
        issue(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].res);
    end

    // Random phases, each under its own slot limit.
    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0:       cap = 4096;
        1:       cap = 0;
        2:       cap = 3;
        3:       cap = 4095;
        4:       cap = $urandom_range(1, 4096);
        5:       cap = $urandom_range(4, 40);
        default: cap = 4096;
      endcase
      set_limit(cap);
      steady = (ph == 3);
      if (ph == 0 || $urandom_range(0, 1))
        issue('{ReqClear, 32'($urandom)}, 1'b0, '0);
      for (int k = 0; k < 90; k++) begin
        roll = $urandom_range(0, 99);
        r.req_type = $urandom_range(0, 1) ? ReqAdd : ReqLookup;
        if (roll < 4) begin
          r = '{ReqClear, 32'($urandom)};
        end else if (roll < 9) begin
          r.key = '0;
        end else if (roll < 13) begin
          r = '{ReqUnused, 32'($urandom)};
        end else if (roll < 50 && live_keys.size() != 0) begin
          r.key = live_keys[$urandom_range(0, live_keys.size() - 1)];
        end else if (roll < 75) begin
          // crowd a few home entries to build probe chains and wrap-round
          r.key = {20'($urandom), hot_pos[$urandom_range(0, 3)]};
        end else begin
          r.key = $urandom;
        end
        issue(r, 1'b0, '0);
      end
    end

    // Drain, then allow for any stray result after the last one due.
    pause(0);
    while (slot_results_due.size() != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
    if (mismatches == 0)
      $display("[key_to_slot_probing_hash_map_top] OK");
    else
      $display("[key_to_slot_probing_hash_map_top] ERROR");
    $finish;
  end

endmodule
